FILE: rtl/bseq_pkg.sv
`timescale 1ns / 1ps
// Package for the branch sequencer: opcode values of the branch group and
// stack fault codes. Depends on nothing; used by the interfaces and the top level.
package bseq_pkg;

	localparam logic [3:0] BRANCH_NIBBLE = 4'hF;

	localparam logic [7:0] OP_CALL   = 8'hF0;
	localparam logic [7:0] OP_JMP    = 8'hF1;
	localparam logic [7:0] OP_RET    = 8'hF2;
	localparam logic [7:0] OP_RETI   = 8'hF3;
	localparam logic [7:0] OP_JL     = 8'hF4;
	localparam logic [7:0] OP_JE     = 8'hF5;
	localparam logic [7:0] OP_JNE    = 8'hF6;
	localparam logic [7:0] OP_JG     = 8'hF7;
	localparam logic [7:0] OP_JZ     = 8'hF8;
	localparam logic [7:0] OP_JNZ    = 8'hF9;
	localparam logic [7:0] OP_JC     = 8'hFA;
	localparam logic [7:0] OP_JNC    = 8'hFB;
	localparam logic [7:0] OP_JHC    = 8'hFC;
	localparam logic [7:0] OP_JHNC   = 8'hFD;
	localparam logic [7:0] OP_AFCALL = 8'hFE;
	localparam logic [7:0] OP_NOPSTOP = 8'hFF;

	typedef logic [15:0] addr_t;
	typedef logic [15:0] word_t;
	typedef logic [1:0]  fault_t;

	localparam fault_t FAULT_NONE  = 2'd0;
	localparam fault_t FAULT_FULL  = 2'd1;
	localparam fault_t FAULT_EMPTY = 2'd2;

endpackage

FILE: rtl/bseq_in_if.sv
`timescale 1ns / 1ps
// Instruction channel: valid/ready handshake with the instruction word and
// the five condition flags. Depends on bseq_pkg.
interface bseq_in_if;
	logic              valid;
	logic              ready;
	bseq_pkg::word_t   instruction_word;
	logic              less_flag;
	logic              equal_flag;
	logic              zero_flag;
	logic              carry_flag;
	logic              half_carry_flag;

	modport source (output valid, instruction_word, less_flag, equal_flag, zero_flag,
		carry_flag, half_carry_flag, input ready);
	modport sink (input valid, instruction_word, less_flag, equal_flag, zero_flag,
		carry_flag, half_carry_flag, output ready);
endinterface

FILE: rtl/bseq_out_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with the next address, halt status
// and stack fault code. Depends on bseq_pkg.
interface bseq_out_if;
	logic              valid;
	logic              ready;
	bseq_pkg::addr_t   next_address;
	logic              halted;
	bseq_pkg::fault_t  stack_fault;

	modport source (output valid, next_address, halted, stack_fault, input ready);
	modport sink (input valid, next_address, halted, stack_fault, output ready);
endinterface

FILE: rtl/bseq_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module bseq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: rtl/branch_sequencer_with_return_stack.sv
`timescale 1ns / 1ps
// Next-address unit with a return-address stack held in bseq_ram.
// Depends on bseq_pkg, bseq_in_if, bseq_out_if and bseq_ram.
//
//   port    role  payload
//   instr   sink  instruction_word, less/equal/zero/carry/half_carry flags
//   result  src   next_address, halted, stack_fault
//
// One item is taken per cycle unless a stalled result blocks it; its result is registered.
// The stack top is read from the RAM ahead of its use, with a bypass after a push,
// so calls and returns may follow each other back to back.
// Reset clears the counter, the stack depth, the halt flag and the output valid.
// A stalled result holds its register; a new item is taken in the cycle it leaves.
module branch_sequencer_with_return_stack #(
	parameter int STACK_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	bseq_in_if.sink     instr,
	bseq_out_if.source  result
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int DW = $clog2(STACK_DEPTH + 1);

	logic              accept;
	bseq_pkg::addr_t   pc_q;
	logic              halt_q;
	logic [DW-1:0]     depth_q;
	logic              byp_q;
	bseq_pkg::addr_t   byp_data_q;
	logic              ovalid_q;

	bseq_pkg::addr_t   pc_nx;
	logic              halt_nx;
	logic [DW-1:0]     depth_nx;
	logic [DW-1:0]     depth_rd;
	logic              push;
	bseq_pkg::fault_t  fault;
	bseq_pkg::addr_t   pc_inc;
	bseq_pkg::addr_t   pc_off;
	bseq_pkg::addr_t   top;
	bseq_pkg::addr_t   rd_data;
	logic [7:0]        op;
	logic [7:0]        low;
	logic              full;
	logic              empty;
	logic              wr_en;
	logic [AW-1:0]     rd_addr;

	assign instr.ready = !ovalid_q || result.ready;
	assign accept      = instr.valid && instr.ready;

	assign op     = instr.instruction_word[15:8];
	assign low    = instr.instruction_word[7:0];
	assign pc_inc = pc_q + 16'd1;
	assign pc_off = pc_q + {{8{low[7]}}, low};
	assign top    = byp_q ? byp_data_q : rd_data;
	assign full   = depth_q == DW'(STACK_DEPTH);
	assign empty  = depth_q == '0;

	always_comb begin
		pc_nx    = pc_q;
		halt_nx  = halt_q;
		depth_nx = depth_q;
		push     = 1'b0;
		fault    = bseq_pkg::FAULT_NONE;
		if (!halt_q) begin
			if (instr.instruction_word[15:12] != bseq_pkg::BRANCH_NIBBLE) begin
				pc_nx = pc_inc;
			end else begin
				unique case (op)
					bseq_pkg::OP_CALL, bseq_pkg::OP_AFCALL: begin
						pc_nx = (op == bseq_pkg::OP_CALL) ? pc_off : {low, 8'h00};
						if (full) begin
							fault = bseq_pkg::FAULT_FULL;
						end else begin
							push     = 1'b1;
							depth_nx = depth_q + DW'(1);
						end
					end
					bseq_pkg::OP_JMP:  pc_nx = pc_off;
					bseq_pkg::OP_RET, bseq_pkg::OP_RETI: begin
						if (empty) begin
							fault = bseq_pkg::FAULT_EMPTY;
							pc_nx = pc_inc;
						end else begin
							depth_nx = depth_q - DW'(1);
							pc_nx    = top;
						end
					end
					bseq_pkg::OP_JL:   pc_nx = instr.less_flag ? pc_off : pc_inc;
					bseq_pkg::OP_JE:   pc_nx = instr.equal_flag ? pc_off : pc_inc;
					bseq_pkg::OP_JNE:  pc_nx = !instr.equal_flag ? pc_off : pc_inc;
					bseq_pkg::OP_JG,
					bseq_pkg::OP_JZ:   pc_nx = instr.zero_flag ? pc_off : pc_inc;
					bseq_pkg::OP_JNZ:  pc_nx = !instr.zero_flag ? pc_off : pc_inc;
					bseq_pkg::OP_JC:   pc_nx = instr.carry_flag ? pc_off : pc_inc;
					bseq_pkg::OP_JNC:  pc_nx = !instr.carry_flag ? pc_off : pc_inc;
					bseq_pkg::OP_JHC:  pc_nx = instr.half_carry_flag ? pc_off : pc_inc;
					bseq_pkg::OP_JHNC: pc_nx = !instr.half_carry_flag ? pc_off : pc_inc;
					default: begin
						pc_nx = pc_inc;
						if (!low[0]) begin
							halt_nx = 1'b1;
						end
					end
				endcase
			end
		end
	end

	// The RAM is always addressed at the entry below the depth of the next cycle,
	// so its registered output, or the bypass register after a push, is the stack top whenever the next item arrives.
	assign wr_en    = accept && push;
	assign depth_rd = (accept ? depth_nx : depth_q) - DW'(1);
	assign rd_addr  = depth_rd[AW-1:0];

	bseq_ram #(
		.WIDTH(16),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (depth_q[AW-1:0]),
		.wr_data (pc_inc),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= '0;
			halt_q   <= 1'b0;
			depth_q  <= '0;
			byp_q    <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			byp_q <= wr_en;
			if (accept) begin
				pc_q    <= pc_nx;
				halt_q  <= halt_nx;
				depth_q <= depth_nx;
			end
			if (accept) begin
				ovalid_q <= 1'b1;
			end else if (result.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			byp_data_q <= pc_inc;
		end
		if (accept) begin
			result.next_address <= pc_nx;
			result.halted       <= halt_nx;
			result.stack_fault  <= fault;
		end
	end

	assign result.valid = ovalid_q;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(STACK_DEPTH))
		else $error("stack depth above capacity");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt flag cleared");

	a_halted_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && halt_q) |=> ($stable(pc_q) && $stable(depth_q)))
		else $error("state changed after halt");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> ($stable(pc_q) && $stable(depth_q)))
		else $error("state changed without an item");

	a_push_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (byp_q && depth_q == $past(depth_q) + DW'(1)))
		else $error("push not reflected in stack top");

endmodule

FILE: bench/tb_branch_sequencer_with_return_stack.sv
`timescale 1ns / 1ps
// Self-checking bench for the branch sequencer: directed and random instruction streams,
// with an in-bench next-address predictor and an ordered check of every result.
// Depends on bseq_pkg, bseq_in_if, bseq_out_if and the branch_sequencer_with_return_stack RTL.
module tb_branch_sequencer_with_return_stack;

	localparam int RAS_DEPTH = 16;
	localparam int RANDOM_ITEMS = 1525;
	localparam int HOLD_CYCLES = 60;
	localparam int DRAIN_CYCLES = 10;

	typedef struct {
		bseq_pkg::word_t word;
		logic  less;
		logic  equal;
		logic  zero;
		logic  carry;
		logic  half_carry;
		int    phase;
		bit    drain_first;
		bit    hold;
	} instr_item_t;

	typedef struct {
		bseq_pkg::addr_t  next_address;
		logic             halted;
		bseq_pkg::fault_t stack_fault;
	} outcome_t;

	logic clk;
	logic arst_n;

	bseq_in_if instr_ch ();
	bseq_out_if result_ch ();

	branch_sequencer_with_return_stack #(
		.STACK_DEPTH(RAS_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.instr(instr_ch.sink),
		.result(result_ch.source)
	);

	instr_item_t pending_q[$];
	outcome_t    expected_results[$];
	int          items_sent;
	int          results_seen;
	int          mismatches;
	int          drive_phase;
	logic        begin_hold;
	int          hold_left;
	bit          mark_drain;
	bit          mark_hold;

	bseq_pkg::addr_t pc_model;
	bseq_pkg::addr_t return_addr [RAS_DEPTH];
	int    depth_model;
	logic  halt_model;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int idle_percent(int ph, bit sender);
		case (ph)
		0: return sender ? 23 : 64;
		1: return sender ? 64 : 23;
		default: return 0;
		endcase
	endfunction

	function automatic bseq_pkg::fault_t push_return(bseq_pkg::addr_t a);
		if (depth_model >= RAS_DEPTH)
			return bseq_pkg::FAULT_FULL;
		return_addr[depth_model] = a;
		depth_model++;
		return bseq_pkg::FAULT_NONE;
	endfunction

	function automatic outcome_t advance_sequencer(instr_item_t it);
		outcome_t        o;
		logic [7:0]      opc;
		logic [7:0]      low;
		bseq_pkg::addr_t rel;
		bseq_pkg::addr_t pc;
		logic            take;
		logic            cond;
		o.stack_fault = bseq_pkg::FAULT_NONE;
		if (!halt_model) begin
			pc = pc_model;
			opc = it.word[15:8];
			low = it.word[7:0];
			rel = {{8{low[7]}}, low};
			take = 1'b0;
			cond = 1'b0;
			if (it.word[15:12] != bseq_pkg::BRANCH_NIBBLE) begin
				pc = pc + 16'd1;
			end else begin
				case (opc)
				bseq_pkg::OP_CALL: begin
					o.stack_fault = push_return(pc + 16'd1);
					pc = pc + rel;
				end
				bseq_pkg::OP_JMP: pc = pc + rel;
				bseq_pkg::OP_RET, bseq_pkg::OP_RETI: begin
					if (depth_model == 0) begin
						o.stack_fault = bseq_pkg::FAULT_EMPTY;
						pc = pc + 16'd1;
					end else begin
						depth_model--;
						pc = return_addr[depth_model];
					end
				end
				bseq_pkg::OP_JL: begin cond = 1'b1; take = it.less; end
				bseq_pkg::OP_JE: begin cond = 1'b1; take = it.equal; end
				bseq_pkg::OP_JNE: begin cond = 1'b1; take = !it.equal; end
				bseq_pkg::OP_JG, bseq_pkg::OP_JZ: begin cond = 1'b1; take = it.zero; end
				bseq_pkg::OP_JNZ: begin cond = 1'b1; take = !it.zero; end
				bseq_pkg::OP_JC: begin cond = 1'b1; take = it.carry; end
				bseq_pkg::OP_JNC: begin cond = 1'b1; take = !it.carry; end
				bseq_pkg::OP_JHC: begin cond = 1'b1; take = it.half_carry; end
				bseq_pkg::OP_JHNC: begin cond = 1'b1; take = !it.half_carry; end
				bseq_pkg::OP_AFCALL: begin
					o.stack_fault = push_return(pc + 16'd1);
					pc = {low, 8'h00};
				end
				default: begin
					pc = pc + 16'd1;
					if (!low[0])
						halt_model = 1'b1;
				end
				endcase
				if (cond)
					pc = take ? pc + rel : pc + 16'd1;
			end
			pc_model = pc;
		end
		o.next_address = pc_model;
		o.halted = halt_model;
		return o;
	endfunction

	function automatic void queue_item(bseq_pkg::word_t w, logic [4:0] flags, int ph);
		instr_item_t it;
		it.word = w;
		{it.less, it.equal, it.zero, it.carry, it.half_carry} = flags;
		it.phase = ph;
		it.drain_first = mark_drain;
		it.hold = mark_hold;
		mark_drain = 0;
		mark_hold = 0;
		pending_q.push_back(it);
	endfunction

	function automatic logic [7:0] push_op();
		return $urandom_range(1) ? bseq_pkg::OP_CALL : bseq_pkg::OP_AFCALL;
	endfunction

	function automatic logic [7:0] pop_op();
		return $urandom_range(1) ? bseq_pkg::OP_RET : bseq_pkg::OP_RETI;
	endfunction

	task automatic note_mismatch(string what, outcome_t want, outcome_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%t: %s: expected addr %h halted %b fault %0d, got addr %h halted %b fault %0d",
				$realtime, what, want.next_address, want.halted, want.stack_fault,
				got.next_address, got.halted, got.stack_fault);
	endtask

	// Driver: an offered item stays on the bus until it is accepted.
	always @(posedge clk or negedge arst_n) begin
		instr_item_t head;
		logic        launch;
		if (!arst_n) begin
			instr_ch.valid <= 1'b0;
			instr_ch.instruction_word <= '0;
			instr_ch.less_flag <= 1'b0;
			instr_ch.equal_flag <= 1'b0;
			instr_ch.zero_flag <= 1'b0;
			instr_ch.carry_flag <= 1'b0;
			instr_ch.half_carry_flag <= 1'b0;
			begin_hold <= 1'b0;
			drive_phase <= 0;
			items_sent = 0;
		end else begin
			if (instr_ch.valid && instr_ch.ready)
				items_sent++;
			launch = 1'b0;
			head.hold = 1'b0;
			if ((!instr_ch.valid || instr_ch.ready) && pending_q.size() != 0) begin
				head = pending_q[0];
				if (!head.drain_first || items_sent == results_seen)
					launch = $urandom_range(99) >= idle_percent(head.phase, 1'b1);
			end
			if (launch) begin
				void'(pending_q.pop_front());
				instr_ch.instruction_word <= head.word;
				instr_ch.less_flag <= head.less;
				instr_ch.equal_flag <= head.equal;
				instr_ch.zero_flag <= head.zero;
				instr_ch.carry_flag <= head.carry;
				instr_ch.half_carry_flag <= head.half_carry;
				drive_phase <= head.phase;
			end
			if (!instr_ch.valid || instr_ch.ready)
				instr_ch.valid <= launch;
			begin_hold <= launch && head.hold;
		end
	end

	// Result side: random back-pressure, plus a long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			hold_left = 0;
		end else if (hold_left != 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else if (begin_hold) begin
			hold_left = HOLD_CYCLES;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= $urandom_range(99) >= idle_percent(drive_phase, 1'b0);
		end
	end

	// Monitor: checks each result against the oldest prediction, then predicts new items.
	always @(posedge clk or negedge arst_n) begin
		outcome_t got;
		outcome_t want;
		instr_item_t seen;
		if (!arst_n) begin
			results_seen <= 0;
			pc_model = '0;
			depth_model = 0;
			halt_model = 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				results_seen <= results_seen + 1;
				got.next_address = result_ch.next_address;
				got.halted = result_ch.halted;
				got.stack_fault = result_ch.stack_fault;
				if (expected_results.size() == 0) begin
					want = '{'0, 1'b0, bseq_pkg::FAULT_NONE};
					note_mismatch("unexpected result", want, got);
				end else begin
					want = expected_results.pop_front();
					if (got.next_address !== want.next_address || got.halted !== want.halted
						|| got.stack_fault !== want.stack_fault)
						note_mismatch("wrong result", want, got);
				end
			end
			if (instr_ch.valid && instr_ch.ready) begin
				seen.word = instr_ch.instruction_word;
				seen.less = instr_ch.less_flag;
				seen.equal = instr_ch.equal_flag;
				seen.zero = instr_ch.zero_flag;
				seen.carry = instr_ch.carry_flag;
				seen.half_carry = instr_ch.half_carry_flag;
				expected_results.push_back(advance_sequencer(seen));
			end
		end
	end

	initial begin
		int n;
		int ph;
		int last_ph;
		int pick;
		int len;
		bseq_pkg::word_t w;
		arst_n = 1'b0;
		instr_ch.valid = 1'b0;
		instr_ch.instruction_word = '0;
		instr_ch.less_flag = 1'b0;
		instr_ch.equal_flag = 1'b0;
		instr_ch.zero_flag = 1'b0;
		instr_ch.carry_flag = 1'b0;
		instr_ch.half_carry_flag = 1'b0;
		result_ch.ready = 1'b0;
		mismatches = 0;
		mark_drain = 0;
		mark_hold = 0;

		queue_item(16'h0000, 5'h00, 0);
		queue_item(16'hEFFF, 5'h1F, 0);
		queue_item({bseq_pkg::OP_JMP, 8'h7F}, 5'h00, 0);
		queue_item({bseq_pkg::OP_JMP, 8'h80}, 5'h1F, 0);
		queue_item({bseq_pkg::OP_RET, 8'h00}, 5'h00, 0);
		queue_item({bseq_pkg::OP_RETI, 8'hFF}, 5'h1F, 0);
		queue_item({bseq_pkg::OP_CALL, 8'h05}, 5'h00, 0);
		queue_item({bseq_pkg::OP_AFCALL, 8'hFF}, 5'h1F, 0);
		queue_item({bseq_pkg::OP_RET, 8'h12}, 5'h00, 0);
		queue_item({bseq_pkg::OP_RETI, 8'h34}, 5'h00, 0);
		for (int op = bseq_pkg::OP_JL; op <= bseq_pkg::OP_JHNC; op++)
			queue_item({8'(op), 8'(op * 37)}, (op % 2) ? 5'h1F : 5'h00, 0);
		queue_item({bseq_pkg::OP_NOPSTOP, 8'h01}, 5'h00, 0);

		// Fill the stack past full, then empty it past empty.
		n = 0;
		repeat (18) queue_item({push_op(), 8'($urandom)}, 5'($urandom), 0);
		repeat (20) queue_item({pop_op(), 8'($urandom)}, 5'($urandom), 0);
		n = 38;
		last_ph = 0;
		while (n < RANDOM_ITEMS) begin
			ph = n * 3 / RANDOM_ITEMS;
			if (ph != last_ph) begin
				mark_drain = 1;
				mark_hold = 1;
				last_ph = ph;
			end
			if ($urandom_range(99) == 0)
				mark_drain = 1;
			pick = $urandom_range(99);
			if (pick < 8) begin
				len = $urandom_range(20, 14);
				repeat (len) queue_item({push_op(), 8'($urandom)}, 5'($urandom), ph);
				n += len;
			end else if (pick < 16) begin
				len = $urandom_range(20, 14);
				repeat (len) queue_item({pop_op(), 8'($urandom)}, 5'($urandom), ph);
				n += len;
			end else if (pick < 24) begin
				do
					w = bseq_pkg::word_t'($urandom);
				while (w[15:8] == bseq_pkg::OP_NOPSTOP && !w[0]);
				queue_item(w, 5'($urandom), ph);
				n++;
			end else begin
				pick = $urandom_range(99);
				if (pick < 2)
					mark_hold = 1;
				if (pick < 34)
					w = {4'($urandom_range(14)), 12'($urandom)};
				else if (pick < 48)
					w = {push_op(), 8'($urandom)};
				else if (pick < 62)
					w = {pop_op(), 8'($urandom)};
				else if (pick < 90)
					w = {8'($urandom_range(bseq_pkg::OP_JHNC, bseq_pkg::OP_JL)), 8'($urandom)};
				else if (pick < 95)
					w = {bseq_pkg::OP_JMP, 8'($urandom)};
				else
					w = {bseq_pkg::OP_NOPSTOP, 7'($urandom), 1'b1};
				queue_item(w, 5'($urandom), ph);
				n++;
			end
		end

		// A stop halts the sequencer for good, so it comes at the end, followed only by two items that it must freeze.
		queue_item({bseq_pkg::OP_NOPSTOP, 8'hFE}, 5'($urandom), 2);
		queue_item({bseq_pkg::OP_CALL, 8'h10}, 5'h1F, 2);
		queue_item(16'h1234, 5'h00, 2);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_q.size() != 0 || instr_ch.valid || items_sent != results_seen)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: files.f
rtl/bseq_pkg.sv
rtl/bseq_in_if.sv
rtl/bseq_out_if.sv
rtl/bseq_ram.sv
rtl/branch_sequencer_with_return_stack.sv
bench/tb_branch_sequencer_with_return_stack.sv
